// ===== src/akd_pkg.sv =====
`default_nettype none

package akd_pkg;

	// Field widths of the sample, the event and the register file.
	localparam int SAMPLE_W    = 12;
	localparam int MV_W        = 12;
	localparam int CODE_W      = 10;
	localparam int TYPE_W      = 5;
	localparam int COUNT_W     = 3;
	localparam int IDX_W       = 3;
	localparam int WINDOW_W    = 39;
	localparam int KEY_SLOTS   = 6;
	localparam int CFG_INDEX_W = 3;
	localparam int QUEUE_DEPTH = 2;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_COUNT    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_FIRST = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_LAST  = 3'd6;

	typedef logic [IDX_W-1:0] key_idx_t;

	// One key's register, laid out as it is written.
	typedef struct packed {
		logic [TYPE_W-1:0] key_type;
		logic [CODE_W-1:0] code;
		logic [MV_W-1:0]   max_mv;
		logic [MV_W-1:0]   min_mv;
	} key_window_t;

	// What the classifier decided: a press or a release of one key slot.
	typedef struct packed {
		logic     pressed;
		key_idx_t idx;
	} key_action_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// A configured type of zero is reported as type one.
	function automatic logic [TYPE_W-1:0] event_type_of(key_window_t w);
		return (w.key_type == '0) ? TYPE_W'(1) : w.key_type;
	endfunction

endpackage

`default_nettype wire

// ===== src/akd_channels.sv =====
`default_nettype none

interface akd_sample_if import akd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] adc_sample;
	logic                sample_valid;

	modport source (output valid, output adc_sample, output sample_valid, input ready);
	modport sink   (input valid, input adc_sample, input sample_valid, output ready);
endinterface

interface akd_event_if import akd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              key_pressed;
	logic [CODE_W-1:0] key_code;
	logic [TYPE_W-1:0] event_type;

	modport source (output valid, output key_pressed, output key_code, output event_type,
		input ready);
	modport sink   (input valid, input key_pressed, input key_code, input event_type,
		output ready);
endinterface

`default_nettype wire

// ===== src/akd_front.sv =====
`default_nettype none

module akd_front import akd_pkg::*; #(
	parameter int MAX_KEYS      = 6,
	parameter int FULL_SCALE_MV = 3300
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	akd_sample_if.sink         sample,
	input  wire logic [COUNT_W-1:0] key_count,
	input  wire key_window_t   windows [KEY_SLOTS],
	input  wire queue_status_t q_status,
	output logic               push,
	output key_action_t        action
);

	localparam logic [MV_W-1:0]    SCALE     = MV_W'(FULL_SCALE_MV);
	localparam logic [COUNT_W-1:0] KEY_LIMIT = COUNT_W'(MAX_KEYS);

	logic [2*SAMPLE_W-1:0] product;
	logic                  take;
	logic                  advance;
	logic                  valid_s1;
	logic [MV_W-1:0]       mv_s1;
	logic                  last_valid_q;
	key_idx_t              last_idx_q;
	logic [COUNT_W-1:0]    active;
	logic                  found;
	key_idx_t              hit;

	assign product = (2*SAMPLE_W)'(sample.adc_sample) * (2*SAMPLE_W)'(SCALE);

	// The first stage holds the millivolt value; the second classifies it.
	assign advance      = valid_s1 && !q_status.full;
	assign sample.ready = !valid_s1 || advance;
	assign take         = sample.valid && sample.ready;

	assign active = (key_count > KEY_LIMIT) ? KEY_LIMIT : key_count;

	// Scan from the top so that the lowest matching slot wins.
	always_comb begin
		found = 1'b0;
		hit   = '0;
		for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
			if (COUNT_W'(i) < active && mv_s1 >= windows[i].min_mv &&
					mv_s1 <= windows[i].max_mv) begin
				found = 1'b1;
				hit   = IDX_W'(i);
			end
		end
	end

	assign push           = advance && (found || last_valid_q);
	assign action.pressed = found;
	assign action.idx     = found ? hit : last_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			last_valid_q <= 1'b0;
			last_idx_q   <= '0;
		end else begin
			if (take) begin
				valid_s1 <= sample.sample_valid;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				last_valid_q <= found;
				last_idx_q   <= found ? hit : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mv_s1 <= product[SAMPLE_W +: MV_W];
		end
	end

endmodule

`default_nettype wire

// ===== src/akd_queue.sv =====
`default_nettype none

module akd_queue import akd_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire key_action_t push_data,
	input  wire logic    pop,
	output key_action_t  head,
	output queue_status_t status
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	key_action_t      entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head         = entries_q[rd_ptr_q];
	assign status.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== src/akd_back.sv =====
`default_nettype none

module akd_back import akd_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire key_action_t head,
	input  wire queue_status_t q_status,
	input  wire key_window_t windows [KEY_SLOTS],
	output logic         pop,
	akd_event_if.source  key_event
);

	key_window_t       sel;
	logic              out_valid_q;
	logic              pressed_q;
	logic [CODE_W-1:0] code_q;
	logic [TYPE_W-1:0] type_q;

	// The output register refills from the queue whenever the queue is not empty and the register is empty or being taken.
	assign pop = !q_status.empty && (!out_valid_q || key_event.ready);
	assign sel = windows[head.idx];

	assign key_event.valid       = out_valid_q;
	assign key_event.key_pressed = pressed_q;
	assign key_event.key_code    = code_q;
	assign key_event.event_type  = type_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (key_event.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pressed_q <= head.pressed;
			code_q    <= sel.code;
			type_q    <= event_type_of(sel);
		end
	end

endmodule

`default_nettype wire

// ===== src/adc_ladder_key_decoder.sv =====
// Resistor-ladder keypad decoder. Each word on the sample channel carries one
// 12-bit converter result and a flag that says whether the conversion
// completed. A completed conversion is scaled to millivolts and compared
// against up to six key windows; the lowest-numbered window that holds it
// gives a press word on the key_event channel, and otherwise the key that was
// last pressed, if any, gives a release word. A timed-out conversion is
// taken and dropped without a word and without touching the remembered key.
// One sample is taken every cycle unless a full queue stalls the classifier.
// The value is scaled to millivolts and registered as the sample is taken,
// then classified and written into the queue; the key's code and type are
// then looked up into the output register, which shows the result word. Key
// windows and the key count are written through the plain write port; the
// user must write them only while the block has nothing in flight, which the
// block does not enforce. A release reports the code and type held in the
// key's register as it leaves the queue. Reset clears the key count, every
// window and the remembered key, and empties the queue and output register.
// When the receiver holds ready low the output register keeps its word, the
// two-entry queue fills, the classifier stalls and sample.ready drops.
`default_nettype none

module adc_ladder_key_decoder import akd_pkg::*; #(
	parameter int MAX_KEYS      = 6,
	parameter int FULL_SCALE_MV = 3300
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	akd_sample_if.sink                  sample,
	akd_event_if.source                 key_event,
	input  wire logic                   cfg_wr_en,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [WINDOW_W-1:0]    cfg_data
);

	logic [COUNT_W-1:0]     key_count_q;
	key_window_t            windows_q [KEY_SLOTS];
	logic [CFG_INDEX_W-1:0] win_sel;
	logic                   push;
	logic                   pop;
	key_action_t            action;
	key_action_t            head;
	queue_status_t          q_status;

	// Window registers start right after the key count in the register map.
	assign win_sel = cfg_index - CFG_WINDOW_FIRST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= '0;
			for (int i = 0; i < KEY_SLOTS; i++) begin
				windows_q[i] <= '0;
			end
		end else if (cfg_wr_en) begin
			case (cfg_index) inside
				CFG_KEY_COUNT: begin
					key_count_q <= cfg_data[COUNT_W-1:0];
				end
				[CFG_WINDOW_FIRST:CFG_WINDOW_LAST]: begin
					windows_q[win_sel] <= key_window_t'(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	// Front end: scales the sample and decides between press, release and
	// nothing, keeping track of the remembered key.
	akd_front #(
		.MAX_KEYS      (MAX_KEYS),
		.FULL_SCALE_MV (FULL_SCALE_MV)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample),
		.key_count (key_count_q),
		.windows   (windows_q),
		.q_status  (q_status),
		.push      (push),
		.action    (action)
	);

	// Decisions wait here so that a stalled receiver does not stop sampling
	// straight away.
	akd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (action),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	// Back end: turns a decision into the reported code and type.
	akd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_status  (q_status),
		.windows   (windows_q),
		.pop       (pop),
		.key_event (key_event)
	);

endmodule

`default_nettype wire
